>>> hw/rtl/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types, constants and helpers for the packed field array block.
// ----------------------------------------------------------------------------
package pfa_pkg;

	localparam int unsigned STORE_WORDS = 1024;
	localparam int unsigned WORD_BITS   = 32;
	localparam int unsigned ADDR_W      = $clog2(STORE_WORDS);
	localparam int unsigned OFF_W       = $clog2(WORD_BITS);
	localparam int unsigned WIDTH_W     = 6;
	localparam int unsigned COUNT_W     = 16;
	localparam int unsigned INDEX_W     = 15;
	localparam int unsigned BITPOS_W    = INDEX_W + WIDTH_W;
	localparam int unsigned BASE_W      = BITPOS_W - OFF_W;
	localparam int unsigned CFG_IDX_W   = 1;
	localparam int unsigned CFG_DATA_W  = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_WIDTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_COUNT = 1'b1;

	typedef enum logic {
		OP_READ  = 1'b0,
		OP_WRITE = 1'b1
	} opcode_t;

	typedef struct packed {
		opcode_t              opcode;
		logic [INDEX_W-1:0]   element_index;
		logic [WORD_BITS-1:0] write_value;
	} req_item_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] read_value;
		logic                 fault;
	} rsp_item_t;

	typedef struct packed {
		logic take;
		logic geom;
		logic base;
		logic top;
		logic clear_en;
		logic load_out;
	} pfa_cmd_t;

	typedef struct packed {
		logic geom_fault;
		logic split;
		logic clear_done;
	} pfa_status_t;

	function automatic logic [WORD_BITS-1:0] low_mask(input logic [WIDTH_W-1:0] n);
		logic [WORD_BITS-1:0] m;
		if (n >= WIDTH_W'(WORD_BITS)) begin
			m = '1;
		end else begin
			m = (WORD_BITS'(1) << n) - WORD_BITS'(1);
		end
		return m;
	endfunction

endpackage

>>> hw/rtl/pfa_datapath.sv
// ----------------------------------------------------------------------------
// pfa_datapath
// Configuration registers, element geometry, word store and result register.
// ----------------------------------------------------------------------------
module pfa_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pfa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pfa_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  pfa_pkg::req_item_t                 req,
	input  pfa_pkg::pfa_cmd_t                  cmd,
	output pfa_pkg::pfa_status_t               status,
	output pfa_pkg::rsp_item_t                 rsp
);

	logic [pfa_pkg::WIDTH_W-1:0]   width_q;
	logic [pfa_pkg::COUNT_W-1:0]   count_q;
	logic [pfa_pkg::ADDR_W-1:0]    clr_addr_q;

	pfa_pkg::opcode_t              op_q;
	logic [pfa_pkg::WORD_BITS-1:0] wval_q;
	logic [pfa_pkg::BITPOS_W-1:0]  bitpos_q;
	logic                          early_fault_q;

	logic [pfa_pkg::ADDR_W-1:0]    base_q;
	logic [pfa_pkg::OFF_W-1:0]     off_q;
	logic                          split_q;
	logic [pfa_pkg::WORD_BITS-1:0] mask_q;
	logic [pfa_pkg::WORD_BITS-1:0] hmask_q;
	logic                          fault_q;
	logic [pfa_pkg::WORD_BITS-1:0] result_q;
	logic [pfa_pkg::WORD_BITS-1:0] rdata_q;
	pfa_pkg::rsp_item_t            rsp_q;

	logic [pfa_pkg::WORD_BITS-1:0] store_mem [pfa_pkg::STORE_WORDS];

	logic [pfa_pkg::OFF_W-1:0]     geo_off;
	logic [pfa_pkg::BASE_W-1:0]    geo_base;
	logic [pfa_pkg::WIDTH_W-1:0]   geo_room;
	logic                          geo_split;
	logic [pfa_pkg::WIDTH_W-1:0]   geo_hbits;
	logic [pfa_pkg::BASE_W:0]      geo_top;
	logic                          geo_fault;
	logic                          early_fault;

	logic [pfa_pkg::ADDR_W-1:0]    top_addr;
	logic [pfa_pkg::WIDTH_W-1:0]   hi_shift;
	logic [pfa_pkg::WORD_BITS-1:0] wv;
	logic [pfa_pkg::WORD_BITS-1:0] lo_data;
	logic [pfa_pkg::WORD_BITS-1:0] lo_clr;
	logic [pfa_pkg::WORD_BITS-1:0] hi_data;

	logic                          mem_we;
	logic [pfa_pkg::ADDR_W-1:0]    mem_waddr;
	logic [pfa_pkg::WORD_BITS-1:0] mem_wdata;
	logic                          mem_re;
	logic [pfa_pkg::ADDR_W-1:0]    mem_raddr;

	assign early_fault = (width_q == '0)
		|| (width_q > pfa_pkg::WIDTH_W'(pfa_pkg::WORD_BITS))
		|| ({1'b0, req.element_index} >= count_q);

	assign geo_off   = bitpos_q[pfa_pkg::OFF_W-1:0];
	assign geo_base  = bitpos_q[pfa_pkg::BITPOS_W-1:pfa_pkg::OFF_W];
	assign geo_room  = pfa_pkg::WIDTH_W'(pfa_pkg::WORD_BITS) - pfa_pkg::WIDTH_W'(geo_off);
	assign geo_split = geo_room < width_q;
	assign geo_hbits = pfa_pkg::WIDTH_W'(geo_off) + width_q
		- pfa_pkg::WIDTH_W'(pfa_pkg::WORD_BITS);
	assign geo_top   = {1'b0, geo_base} + (pfa_pkg::BASE_W + 1)'(geo_split);
	assign geo_fault = early_fault_q
		|| (geo_top >= (pfa_pkg::BASE_W + 1)'(pfa_pkg::STORE_WORDS));

	assign top_addr = base_q + pfa_pkg::ADDR_W'(1);
	assign hi_shift = pfa_pkg::WIDTH_W'(pfa_pkg::WORD_BITS) - pfa_pkg::WIDTH_W'(off_q);
	assign wv       = wval_q & mask_q;
	assign lo_data  = wv << off_q;
	assign lo_clr   = mask_q << off_q;
	assign hi_data  = wv >> hi_shift;

	assign mem_re    = cmd.geom | cmd.base;
	assign mem_raddr = cmd.geom ? geo_base[pfa_pkg::ADDR_W-1:0] : top_addr;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_addr_q;
		mem_wdata = '0;
		if (cmd.clear_en) begin
			mem_we = 1'b1;
		end else if (cmd.base && op_q == pfa_pkg::OP_WRITE) begin
			mem_we    = 1'b1;
			mem_waddr = base_q;
			mem_wdata = (rdata_q & ~lo_clr) | lo_data;
		end else if (cmd.top && op_q == pfa_pkg::OP_WRITE) begin
			mem_we    = 1'b1;
			mem_waddr = top_addr;
			mem_wdata = (rdata_q & ~hmask_q) | (hi_data & hmask_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= '0;
			count_q    <= '0;
			clr_addr_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					pfa_pkg::REG_ELEMENT_WIDTH: width_q <= cfg_data[pfa_pkg::WIDTH_W-1:0];
					pfa_pkg::REG_ELEMENT_COUNT: count_q <= cfg_data[pfa_pkg::COUNT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.clear_en) begin
				clr_addr_q <= clr_addr_q + pfa_pkg::ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q          <= req.opcode;
			wval_q        <= req.write_value;
			bitpos_q      <= pfa_pkg::BITPOS_W'(req.element_index)
				* pfa_pkg::BITPOS_W'(width_q);
			early_fault_q <= early_fault;
		end
		if (cmd.geom) begin
			base_q  <= geo_base[pfa_pkg::ADDR_W-1:0];
			off_q   <= geo_off;
			split_q <= geo_split;
			mask_q  <= pfa_pkg::low_mask(width_q);
			hmask_q <= geo_split ? pfa_pkg::low_mask(geo_hbits) : '0;
			fault_q <= geo_fault;
		end
		if (cmd.base) begin
			result_q <= (rdata_q >> off_q) & mask_q;
		end
		if (cmd.top) begin
			result_q <= result_q | ((rdata_q & hmask_q) << hi_shift);
		end
		if (cmd.load_out) begin
			rsp_q.fault      <= fault_q;
			rsp_q.read_value <= (fault_q || op_q == pfa_pkg::OP_WRITE) ? '0 : result_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= store_mem[mem_raddr];
		end
	end

	assign status.geom_fault = geo_fault;
	assign status.split      = split_q;
	assign status.clear_done = clr_addr_q == pfa_pkg::ADDR_W'(pfa_pkg::STORE_WORDS - 1);
	assign rsp               = rsp_q;

endmodule

>>> hw/rtl/pfa_ctrl.sv
// ----------------------------------------------------------------------------
// pfa_ctrl
// Sequencer for store clearing, element access steps and result handoff.
// ----------------------------------------------------------------------------
module pfa_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	input  pfa_pkg::pfa_status_t  status,
	output pfa_pkg::pfa_cmd_t     cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_GEOM,
		ST_BASE,
		ST_TOP,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   rsp_free;

	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = state_q != ST_IDLE;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.take     = (state_q == ST_IDLE) && req_valid;
		cmd.geom     = state_q == ST_GEOM;
		cmd.base     = state_q == ST_BASE;
		cmd.top      = state_q == ST_TOP;
		cmd.clear_en = state_q == ST_CLEAR;
		cmd.load_out = (state_q == ST_DONE) && rsp_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (status.clear_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_GEOM;
					end
				end
				ST_GEOM: begin
					state_q <= status.geom_fault ? ST_DONE : ST_BASE;
				end
				ST_BASE: begin
					state_q <= status.split ? ST_TOP : ST_DONE;
				end
				ST_TOP: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_top_needs_split: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TOP) |-> ($past(state_q) == ST_BASE) && $past(status.split))
		else $error("second word step without a straddling element");

	a_load_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> rsp_valid)
		else $error("loaded result not presented");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |-> !cmd.load_out)
		else $error("waiting result overwritten");

	a_clear_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && $past(state_q) == ST_CLEAR) |-> $past(status.clear_done))
		else $error("left clearing pass early");

endmodule

>>> hw/rtl/packed_field_array_access_top.sv
// ----------------------------------------------------------------------------
// packed_field_array_access_top
// Packed array of 1..32 bit elements held in a 1R/1W dual-port word store.
//
// Request channel (req_valid/req_stall/req) carries a read or write of one
// element by index; each request yields exactly one transfer on the response
// channel (rsp_valid/rsp_stall/rsp) with the read value and a fault flag.
// Element width and count are set through cfg_we/cfg_index/cfg_data. The
// user must write them only while no request is in flight; the block
// does not enforce it. After reset the store is swept to zero, one word a
// cycle, over all STORE_WORDS (1024) words; req_stall stays high during
// the sweep. A request passes a geometry step, then a step on the base word
// and, if the element straddles two words, one on the top word, before its
// response is loaded; a fault goes from the geometry step to the response.
// A new request is taken only once the previous one is back in idle; the
// read-modify-write of the store, one word per step, sets the pace.
// A finished response waits in an output register while rsp_stall is high;
// the block then takes the next request and holds its result until the
// output register frees.
// ----------------------------------------------------------------------------
module packed_field_array_access_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  pfa_pkg::req_item_t             req,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output pfa_pkg::rsp_item_t             rsp,
	input  logic                           cfg_we,
	input  logic [pfa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pfa_pkg::CFG_DATA_W-1:0] cfg_data
);

	pfa_pkg::pfa_cmd_t    cmd;
	pfa_pkg::pfa_status_t status;

	pfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.cmd       (cmd)
	);

	pfa_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.cmd       (cmd),
		.status    (status),
		.rsp       (rsp)
	);

endmodule
